// ===== rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// shared constants, operation and status codes, memory request structs
// ----------------------------------------------------------------------------
package ssp_pkg;

    // sizes
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = 8;
    localparam int VAL_W    = 8;
    localparam int CNT_W    = 9;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

    // entry list access, one read and one write port
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
    } list_req_t;

    // presence map access, one read and one write port
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              wr_data;
    } pres_req_t;

endpackage

// ===== rtl/ssp_list_mem.sv =====
// ----------------------------------------------------------------------------
// ssp_list_mem
// dense entry list, synchronous memory with registered read data
// ----------------------------------------------------------------------------
module ssp_list_mem (
    input  logic                     clk,
    input  ssp_pkg::list_req_t       req,
    output logic [ssp_pkg::VAL_W-1:0] rd_data
);
    import ssp_pkg::*;

    logic [VAL_W-1:0] mem [CAPACITY];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== rtl/ssp_presence_mem.sv =====
// ----------------------------------------------------------------------------
// ssp_presence_mem
// presence map memory; per-entry valid bits make unwritten entries read zero
// ----------------------------------------------------------------------------
module ssp_presence_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  ssp_pkg::pres_req_t req,
    output logic               rd_data
);
    import ssp_pkg::*;

    logic                mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic                data_q;
    logic                valid_q;

    // valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            data_q  <= mem[req.rd_addr];
            valid_q <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = data_q & valid_q;

endmodule

// ===== rtl/sparse_set_with_presence_map_core.sv =====
// ----------------------------------------------------------------------------
// sparse_set_with_presence_map_core
// add and rejected items need no memory read, contains and read do one lookup,
// remove scans up to the match and moves the last entry into the hole, clear
// walks every listed entry; one item at a time, set by the single list memory
// port walk. a new item is taken the cycle after the result enters the output
// register. reset empties the list and the presence map, size_in_use = 256
// ----------------------------------------------------------------------------
module sparse_set_with_presence_map_core (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ssp_pkg::CNT_W-1:0]  cfg_data,
    // input transaction
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ssp_pkg::FUNC_W-1:0] func,
    input  logic [ssp_pkg::VAL_W-1:0]  value,
    input  logic [ssp_pkg::ADDR_W-1:0] position,
    // result transaction
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       present,
    output logic [ssp_pkg::VAL_W-1:0]  read_value,
    output logic [ssp_pkg::CNT_W-1:0]  count,
    output logic [ssp_pkg::STAT_W-1:0] status
);
    import ssp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LAST  = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] match_reg, match_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  size_reg;
    logic              res_present_reg, res_present_next;
    logic [VAL_W-1:0]  res_rdval_reg, res_rdval_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;

    logic              out_valid_reg;
    logic              out_present_reg;
    logic [VAL_W-1:0]  out_rdval_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [STAT_W-1:0] out_status_reg;

    list_req_t         list_req;
    pres_req_t         pres_req;
    logic [VAL_W-1:0]  list_rd_data;
    logic              pres_rd_data;

    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  last_idx;
    logic              out_free;
    logic              out_load;
    logic              val_oor;
    logic              pos_oor;

    // memories
    ssp_list_mem u_list (
        .clk     (clk),
        .req     (list_req),
        .rd_data (list_rd_data)
    );

    ssp_presence_mem u_presence (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (pres_req),
        .rd_data (pres_rd_data)
    );

    // limit in force and range checks
    assign lim      = (size_reg > CAP_CNT) ? CAP_CNT : size_reg;
    assign val_oor  = ({1'b0, value} >= lim);
    assign pos_oor  = ({1'b0, position} >= lim);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign last_idx = count_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_RESP) && out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        value_next       = value_reg;
        idx_next         = idx_reg;
        match_next       = match_reg;
        count_next       = count_reg;
        res_present_next = res_present_reg;
        res_rdval_next   = res_rdval_reg;
        res_status_next  = res_status_reg;
        list_req         = '0;
        pres_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next        = func;
                    value_next       = value;
                    res_present_next = 1'b0;
                    res_rdval_next   = '0;
                    res_status_next  = STAT_OK;
                    state_next       = S_RESP;
                    case (func)
                        FUNC_ADD:
                        begin
                            if (val_oor)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else if (count_reg >= lim)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                list_req.wr_en   = 1'b1;
                                list_req.wr_addr = count_reg[ADDR_W-1:0];
                                list_req.wr_data = value;
                                pres_req.wr_en   = 1'b1;
                                pres_req.wr_addr = value;
                                pres_req.wr_data = 1'b1;
                                count_next       = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (val_oor)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else if (count_reg == '0)
                            begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                list_req.rd_en   = 1'b1;
                                list_req.rd_addr = '0;
                                idx_next         = '0;
                                state_next       = S_SCAN;
                            end
                        end
                        FUNC_CONTAINS:
                        begin
                            if (val_oor)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                pres_req.rd_en   = 1'b1;
                                pres_req.rd_addr = value;
                                state_next       = S_READ;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            if (count_reg != '0)
                            begin
                                list_req.rd_en   = 1'b1;
                                list_req.rd_addr = '0;
                                idx_next         = '0;
                                state_next       = S_CLEAR;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (pos_oor)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                list_req.rd_en   = 1'b1;
                                list_req.rd_addr = position;
                                state_next       = S_READ;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_RANGE;
                        end
                    endcase
                end
            end

            // single lookup result
            S_READ:
            begin
                if (func_reg == FUNC_CONTAINS)
                begin
                    res_present_next = pres_rd_data;
                end
                else
                begin
                    res_rdval_next = list_rd_data;
                end
                state_next = S_RESP;
            end

            // search for the first matching entry
            S_SCAN:
            begin
                if (list_rd_data == value_reg)
                begin
                    match_next       = idx_reg[ADDR_W-1:0];
                    list_req.rd_en   = 1'b1;
                    list_req.rd_addr = last_idx[ADDR_W-1:0];
                    state_next       = S_LAST;
                end
                else if (idx_inc < count_reg)
                begin
                    list_req.rd_en   = 1'b1;
                    list_req.rd_addr = idx_inc[ADDR_W-1:0];
                    idx_next         = idx_inc;
                end
                else
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_RESP;
                end
            end

            // move the last entry into the hole
            S_LAST:
            begin
                list_req.wr_en   = 1'b1;
                list_req.wr_addr = match_reg;
                list_req.wr_data = list_rd_data;
                pres_req.wr_en   = 1'b1;
                pres_req.wr_addr = value_reg;
                pres_req.wr_data = 1'b0;
                count_next       = last_idx;
                state_next       = S_RESP;
            end

            // drop the presence bit of every listed value
            S_CLEAR:
            begin
                pres_req.wr_en   = 1'b1;
                pres_req.wr_addr = list_rd_data;
                pres_req.wr_data = 1'b0;
                if (idx_inc < count_reg)
                begin
                    list_req.rd_en   = 1'b1;
                    list_req.rd_addr = idx_inc[ADDR_W-1:0];
                    idx_next         = idx_inc;
                end
                else
                begin
                    count_next = '0;
                    state_next = S_RESP;
                end
            end

            // hand the result to the output register
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            size_reg  <= CAP_CNT;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        value_reg       <= value_next;
        idx_reg         <= idx_next;
        match_reg       <= match_next;
        res_present_reg <= res_present_next;
        res_rdval_reg   <= res_rdval_next;
        res_status_reg  <= res_status_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_present_reg <= res_present_reg;
            out_rdval_reg   <= res_rdval_reg;
            out_count_reg   <= count_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign present    = out_present_reg;
    assign read_value = out_rdval_reg;
    assign count      = out_count_reg;
    assign status     = out_status_reg;

`ifndef SYNTHESIS
    // list never grows past its capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // walks stay inside the listed entries
    a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_CLEAR) |-> idx_reg < count_reg)
        else $error("walk index past entry count");

    // a match always has a last entry to move
    a_last_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAST) |-> count_reg != '0)
        else $error("remove on empty list");

    // a result only enters the output register from the response state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result issued outside response state");
`endif

endmodule
